// ===== sv/dle_pkg.sv =====
// dle_pkg: shared constants and codes for the duplicate list engine
// used by dle_ram users and duplicate_list_engine; depends on nothing
package dle_pkg;

  localparam int LISTS    = 16;
  localparam int DEPTH    = 32;
  localparam int RID_BITS = 64;

  // a count must fit in six bits
  localparam int CAP = (DEPTH > 63) ? 63 : DEPTH;

  localparam int FLAG_W     = 8;
  localparam int CNT_W      = 6;
  localparam int ENT_W      = RID_BITS + FLAG_W;
  localparam int STORE_D    = LISTS * DEPTH;
  localparam int ADDR_W     = $clog2(STORE_D);
  localparam int SLOT_IDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;

  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_OVERWRITE = 3'd1;
  localparam logic [2:0] KIND_ERASE     = 3'd2;
  localparam logic [2:0] KIND_ERASE_ALL = 3'd3;
  localparam logic [2:0] KIND_GET       = 3'd4;
  localparam logic [2:0] KIND_GET_LAST  = 3'd5;

  localparam logic [1:0] MODE_BEFORE = 2'd0;
  localparam logic [1:0] MODE_AFTER  = 2'd1;
  localparam logic [1:0] MODE_FIRST  = 2'd2;
  localparam logic [1:0] MODE_LAST   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        read_rid;
    logic [FLAG_W-1:0]  read_flags;
    logic [CNT_W-1:0]   entry_count;
    logic [CNT_W-1:0]   insert_index;
    logic               free_valid;
    logic [63:0]        free_rid;
    logic               last;
  } result_t;

endpackage

// ===== sv/dle_ram.sv =====
// dle_ram: generic simple dual port ram, one write and one registered read port
// no package dependency
module dle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/duplicate_list_engine.sv =====
// duplicate_list_engine: sixteen ordered lists of duplicate entries kept in one ram
// depends on dle_pkg and dle_ram
//
// One word is taken at a time; in_ready is high only while the engine is idle.
// All list entries live in a single store with one read and one write port, and
// every entry that moves costs a read and a write of the store. Insert moves
// entries up to open its place, erase one moves entries down to close the gap,
// and erase all gives one result word per entry and a final word with last set.
// Results sit in an output register, so a stall on out_ready only holds the
// engine when the next result is due. inline_mask may be written through the
// cfg channel while no item is in progress. Entry counts are cleared by reset;
// the store needs no clearing, since only entries below a list's count are
// ever read.
module duplicate_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dle_pkg::FLAG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   kind,
  input  logic [3:0]                   table_slot,
  input  logic [1:0]                   insert_mode,
  input  logic [5:0]                   position,
  input  logic [63:0]                  entry_rid,
  input  logic [7:0]                   entry_flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [63:0]                  read_rid,
  output logic [7:0]                   read_flags,
  output logic [5:0]                   entry_count,
  output logic [5:0]                   insert_index,
  output logic                         free_valid,
  output logic [63:0]                  free_rid,
  output logic                         last
);

  localparam int CNT_W  = dle_pkg::CNT_W;
  localparam int ADDR_W = dle_pkg::ADDR_W;
  localparam int ENT_W  = dle_pkg::ENT_W;
  localparam int FLAG_W = dle_pkg::FLAG_W;
  localparam int RID_W  = dle_pkg::RID_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_WR,
    S_OVR,
    S_ERS_OLD,
    S_ERS_RD,
    S_ERS_WR,
    S_EA_RD,
    S_EA_EMIT,
    S_GET
  } state_t;

  state_t state;

  logic [2:0]        kind_r;
  logic [3:0]        slot_r;
  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  pos_r;
  logic [RID_W-1:0]  rid_r;
  logic [FLAG_W-1:0] flags_r;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  tgt;
  logic [RID_W-1:0]  old_rid;
  logic [FLAG_W-1:0] old_flags;
  logic [FLAG_W-1:0] inline_mask;
  logic [CNT_W-1:0]  counts [dle_pkg::LISTS];

  dle_pkg::result_t out_r;
  dle_pkg::result_t res;
  logic             out_valid_r;
  logic             emit;
  logic             out_free;
  logic             slot_ok;
  logic             in_slot_ok;
  logic             disp_err;
  logic [CNT_W-1:0] ins_pos;

  // ram control
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [ENT_W-1:0]  rdata;
  logic [RID_W-1:0]  rdata_rid;
  logic [FLAG_W-1:0] rdata_flags;

  dle_ram #(
    .WIDTH (ENT_W),
    .DEPTH (dle_pkg::STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] s,
                                                input logic [CNT_W-1:0] i);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(dle_pkg::DEPTH)) + ADDR_W'(i);
  endfunction

  assign rdata_rid   = rdata[ENT_W-1:FLAG_W];
  assign rdata_flags = rdata[FLAG_W-1:0];

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign slot_ok    = (9'(slot_r) < 9'(dle_pkg::LISTS));
  assign in_slot_ok = (9'(table_slot) < 9'(dle_pkg::LISTS));

  assign out_valid    = out_valid_r;
  assign status       = out_r.status;
  assign read_rid     = out_r.read_rid;
  assign read_flags   = out_r.read_flags;
  assign entry_count  = out_r.entry_count;
  assign insert_index = out_r.insert_index;
  assign free_valid   = out_r.free_valid;
  assign free_rid     = out_r.free_rid;
  assign last         = out_r.last;

  // landing place of an inserted entry
  always_comb begin
    case (mode_r)
      dle_pkg::MODE_BEFORE: ins_pos = (pos_r > cnt) ? cnt : pos_r;
      dle_pkg::MODE_AFTER:  ins_pos = ({1'b0, pos_r} + 7'd1 > {1'b0, cnt}) ? cnt :
                                      CNT_W'({1'b0, pos_r} + 7'd1);
      dle_pkg::MODE_FIRST:  ins_pos = '0;
      dle_pkg::MODE_LAST:   ins_pos = cnt;
      default:              ins_pos = cnt;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    res      = '0;
    res.last = 1'b1;
    disp_err = 1'b0;
    we       = 1'b0;
    waddr    = addr_of(slot_r, idx);
    wdata    = rdata;
    re       = 1'b0;
    raddr    = addr_of(slot_r, idx);
    case (state)
      S_DISPATCH: begin
        res.entry_count = cnt;
        if (!slot_ok) begin
          disp_err        = 1'b1;
          res.status      = dle_pkg::ST_NOT_FOUND;
          res.entry_count = '0;
        end else begin
          case (kind_r)
            dle_pkg::KIND_INSERT: begin
              if (cnt >= CNT_W'(dle_pkg::CAP)) begin
                disp_err   = 1'b1;
                res.status = dle_pkg::ST_FULL;
              end
            end
            dle_pkg::KIND_OVERWRITE, dle_pkg::KIND_ERASE: begin
              if (pos_r >= cnt) begin
                disp_err   = 1'b1;
                res.status = dle_pkg::ST_BAD_POS;
              end else begin
                re    = 1'b1;
                raddr = addr_of(slot_r, pos_r);
              end
            end
            dle_pkg::KIND_ERASE_ALL: begin
            end
            dle_pkg::KIND_GET: begin
              if (pos_r >= cnt) begin
                disp_err   = 1'b1;
                res.status = dle_pkg::ST_NOT_FOUND;
              end else begin
                re    = 1'b1;
                raddr = addr_of(slot_r, pos_r);
              end
            end
            dle_pkg::KIND_GET_LAST: begin
              if (cnt == '0) begin
                disp_err   = 1'b1;
                res.status = dle_pkg::ST_NOT_FOUND;
              end else begin
                re    = 1'b1;
                raddr = addr_of(slot_r, cnt - 1'b1);
              end
            end
            default: begin
              disp_err   = 1'b1;
              res.status = dle_pkg::ST_NOT_FOUND;
            end
          endcase
        end
        emit = disp_err && out_free;
      end
      S_INS_RD: begin
        if (idx > tgt) begin
          re    = 1'b1;
          raddr = addr_of(slot_r, idx - 1'b1);
        end else if (out_free) begin
          we               = 1'b1;
          waddr            = addr_of(slot_r, tgt);
          wdata            = {rid_r, flags_r};
          emit             = 1'b1;
          res.status       = dle_pkg::ST_OK;
          res.entry_count  = cnt + 1'b1;
          res.insert_index = tgt;
        end
      end
      S_INS_WR: begin
        // entry below moves up one place
        we = 1'b1;
      end
      S_OVR: begin
        if (out_free) begin
          we              = 1'b1;
          waddr           = addr_of(slot_r, pos_r);
          wdata           = {rid_r, flags_r};
          emit            = 1'b1;
          res.status      = dle_pkg::ST_OK;
          res.entry_count = cnt;
          res.free_valid  = (rdata_flags & inline_mask) == '0;
          res.free_rid    = res.free_valid ? 64'(rdata_rid) : 64'd0;
        end
      end
      S_ERS_RD: begin
        if ({1'b0, idx} + 7'd1 < {1'b0, cnt}) begin
          re    = 1'b1;
          raddr = addr_of(slot_r, idx + 1'b1);
        end else if (out_free) begin
          emit            = 1'b1;
          res.status      = dle_pkg::ST_OK;
          res.entry_count = cnt - 1'b1;
          res.free_valid  = (old_flags & inline_mask) == '0;
          res.free_rid    = res.free_valid ? 64'(old_rid) : 64'd0;
        end
      end
      S_ERS_WR: begin
        // entry above moves down one place
        we = 1'b1;
      end
      S_EA_RD: begin
        if (idx < cnt) begin
          re = 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          res.status = dle_pkg::ST_OK;
        end
      end
      S_EA_EMIT: begin
        if (out_free) begin
          emit           = 1'b1;
          res.status     = dle_pkg::ST_OK;
          res.last       = 1'b0;
          res.free_valid = (rdata_flags & inline_mask) == '0;
          res.free_rid   = res.free_valid ? 64'(rdata_rid) : 64'd0;
        end
      end
      S_GET: begin
        if (out_free) begin
          emit            = 1'b1;
          res.status      = dle_pkg::ST_OK;
          res.entry_count = cnt;
          res.read_rid    = 64'(rdata_rid);
          res.read_flags  = rdata_flags;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
      inline_mask <= '0;
      for (int i = 0; i < dle_pkg::LISTS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        inline_mask <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind;
            slot_r  <= table_slot;
            mode_r  <= insert_mode;
            pos_r   <= position;
            rid_r   <= entry_rid[RID_W-1:0];
            flags_r <= entry_flags;
            cnt     <= in_slot_ok ? counts[dle_pkg::SLOT_IDX_W'(table_slot)] : '0;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (disp_err) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else begin
            case (kind_r)
              dle_pkg::KIND_INSERT: begin
                idx   <= cnt;
                tgt   <= ins_pos;
                state <= S_INS_RD;
              end
              dle_pkg::KIND_OVERWRITE: state <= S_OVR;
              dle_pkg::KIND_ERASE:     state <= S_ERS_OLD;
              dle_pkg::KIND_ERASE_ALL: begin
                idx   <= '0;
                state <= S_EA_RD;
              end
              default: state <= S_GET;
            endcase
          end
        end
        S_INS_RD: begin
          if (idx > tgt) begin
            state <= S_INS_WR;
          end else if (out_free) begin
            counts[dle_pkg::SLOT_IDX_W'(slot_r)] <= cnt + 1'b1;
            state <= S_IDLE;
          end
        end
        S_INS_WR: begin
          idx   <= idx - 1'b1;
          state <= S_INS_RD;
        end
        S_OVR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_ERS_OLD: begin
          old_rid   <= rdata_rid;
          old_flags <= rdata_flags;
          idx       <= pos_r;
          state     <= S_ERS_RD;
        end
        S_ERS_RD: begin
          if ({1'b0, idx} + 7'd1 < {1'b0, cnt}) begin
            state <= S_ERS_WR;
          end else if (out_free) begin
            counts[dle_pkg::SLOT_IDX_W'(slot_r)] <= cnt - 1'b1;
            state <= S_IDLE;
          end
        end
        S_ERS_WR: begin
          idx   <= idx + 1'b1;
          state <= S_ERS_RD;
        end
        S_EA_RD: begin
          if (idx < cnt) begin
            state <= S_EA_EMIT;
          end else if (out_free) begin
            counts[dle_pkg::SLOT_IDX_W'(slot_r)] <= '0;
            state <= S_IDLE;
          end
        end
        S_EA_EMIT: begin
          if (out_free) begin
            idx   <= idx + 1'b1;
            state <= S_EA_RD;
          end
        end
        S_GET: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
